/* rtl/erpt_pkg.sv */
// shared constants, types and tables for the euler rigid point transform
`default_nettype none
package erpt_pkg;

    localparam int COORD_WIDTH_DEF  = 32;
    localparam int ANGLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int TABLE_LEN = 24;
    localparam int FRAC_BITS = 30;
    localparam int TRIG_W    = 32;
    localparam int ENTRY_W   = 33;
    localparam int Z_W       = 36;
    localparam int XY_W      = 34;
    localparam int PROD2_W   = 2 * TRIG_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_OPS   = 14;

    localparam logic signed [TRIG_W-1:0] Q_ONE   = 32'sd1073741824;
    localparam logic signed [PROD2_W-1:0] Q_HALF = 64'sd536870912;
    localparam logic signed [Z_W-1:0] HALF_PI_Q  = 36'sd1686629713;
    localparam logic signed [Z_W-1:0] PI_Q       = 36'sd3373259426;
    localparam logic signed [XY_W-1:0] GAIN_Q    = 34'sd652032874;

    // register indexes
    localparam logic [2:0] REG_ANGLE_X = 3'd0;
    localparam logic [2:0] REG_ANGLE_Y = 3'd1;
    localparam logic [2:0] REG_ANGLE_Z = 3'd2;
    localparam logic [2:0] REG_SHIFT_X = 3'd3;
    localparam logic [2:0] REG_SHIFT_Y = 3'd4;
    localparam logic [2:0] REG_SHIFT_Z = 3'd5;

    // product sequence codes
    localparam logic [3:0] OP_SXSY  = 4'd0;
    localparam logic [3:0] OP_CXSY  = 4'd1;
    localparam logic [3:0] OP_CYCZ  = 4'd2;
    localparam logic [3:0] OP_CYSZ  = 4'd3;
    localparam logic [3:0] OP_SXCY  = 4'd4;
    localparam logic [3:0] OP_CXCY  = 4'd5;
    localparam logic [3:0] OP_SXSYCZ = 4'd6;
    localparam logic [3:0] OP_CXSZ  = 4'd7;
    localparam logic [3:0] OP_SXSYSZ = 4'd8;
    localparam logic [3:0] OP_CXCZ  = 4'd9;
    localparam logic [3:0] OP_CXSYCZ = 4'd10;
    localparam logic [3:0] OP_SXSZ  = 4'd11;
    localparam logic [3:0] OP_CXSYSZ = 4'd12;
    localparam logic [3:0] OP_SXCZ  = 4'd13;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_LOAD,
        CS_ROT,
        CS_MUL,
        CS_RND,
        CS_MATRIX
    } coef_state_t;

    typedef logic signed [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        logic busy;
    } coef_status_t;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:  v = 36'h03243F6A8;
            5'd1:  v = 36'h01DAC6705;
            5'd2:  v = 36'h00FADBAFC;
            5'd3:  v = 36'h007F56EA6;
            5'd4:  v = 36'h003FEAB76;
            5'd5:  v = 36'h001FFD55B;
            5'd6:  v = 36'h000FFFAAA;
            5'd7:  v = 36'h0007FFF55;
            5'd8:  v = 36'h0003FFFEA;
            5'd9:  v = 36'h0001FFFFD;
            5'd10: v = 36'h0000FFFFF;
            5'd11: v = 36'h00007FFFF;
            5'd12: v = 36'h00003FFFF;
            5'd13: v = 36'h00001FFFF;
            5'd14: v = 36'h00000FFFF;
            5'd15: v = 36'h000007FFF;
            5'd16: v = 36'h000003FFF;
            5'd17: v = 36'h000001FFF;
            5'd18: v = 36'h000000FFF;
            5'd19: v = 36'h0000007FF;
            5'd20: v = 36'h0000003FF;
            5'd21: v = 36'h0000001FF;
            5'd22: v = 36'h0000000FF;
            5'd23: v = 36'h00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/erpt_point_if.sv */
// stream interface carrying input points
`default_nettype none
interface erpt_point_if #(
    parameter int COORD_WIDTH = 32
);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface
`default_nettype wire

/* rtl/erpt_moved_if.sv */
// stream interface carrying transformed points
`default_nettype none
interface erpt_moved_if #(
    parameter int COORD_WIDTH = 32
);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] moved_x;
    logic signed [COORD_WIDTH-1:0] moved_y;
    logic signed [COORD_WIDTH-1:0] moved_z;
    logic clipped;

    modport source (output valid, moved_x, moved_y, moved_z, clipped, input ready);
    modport sink (input valid, moved_x, moved_y, moved_z, clipped, output ready);
endinterface
`default_nettype wire

/* rtl/erpt_coef.sv */
// configuration registers, cordic sine/cosine and rotation matrix builder
`default_nettype none
module erpt_coef #(
    parameter int COORD_WIDTH  = erpt_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = erpt_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = erpt_pkg::CORDIC_STEPS_DEF,
    parameter int PDATA_W      = 32,
    parameter int ADDR_LSB     = 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ADDR_LSB+2:0]           paddr,
    input  wire logic [PDATA_W-1:0]            pwdata,
    output logic      [PDATA_W-1:0]            prdata,
    output erpt_pkg::entry_t                   matrix [9],
    output logic signed [COORD_WIDTH-1:0]      shift [3],
    output erpt_pkg::coef_status_t             status
);
    import erpt_pkg::*;

    localparam int STEPS_USED = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam logic [4:0] LAST_STEP = 5'(STEPS_USED - 1);
    localparam int Z_SHIFT = FRAC_BITS - (ANGLE_WIDTH - 3);

    logic [ANGLE_WIDTH-1:0] ang_reg [3];
    logic [COORD_WIDTH-1:0] shf_reg [3];
    logic signed [TRIG_W-1:0] sin_reg [3];
    logic signed [TRIG_W-1:0] cos_reg [3];
    logic signed [TRIG_W-1:0] res_reg [NUM_OPS];
    entry_t mat_reg [9];

    coef_state_t state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic [4:0] step_reg, step_next;
    logic [3:0] op_reg, op_next;
    logic flip_reg;
    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0] z_reg;
    logic signed [PROD2_W-1:0] prod_reg;

    logic wr_en;
    logic [2:0] wr_idx;
    logic angle_wr;

    assign wr_en    = psel && penable && pwrite;
    assign wr_idx   = paddr[ADDR_LSB+2:ADDR_LSB];
    assign angle_wr = wr_en && (wr_idx == REG_ANGLE_X || wr_idx == REG_ANGLE_Y
                                || wr_idx == REG_ANGLE_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ang_reg[i] <= '0;
                shf_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_ANGLE_X: ang_reg[0] <= pwdata[ANGLE_WIDTH-1:0];
                REG_ANGLE_Y: ang_reg[1] <= pwdata[ANGLE_WIDTH-1:0];
                REG_ANGLE_Z: ang_reg[2] <= pwdata[ANGLE_WIDTH-1:0];
                REG_SHIFT_X: shf_reg[0] <= pwdata[COORD_WIDTH-1:0];
                REG_SHIFT_Y: shf_reg[1] <= pwdata[COORD_WIDTH-1:0];
                REG_SHIFT_Z: shf_reg[2] <= pwdata[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            REG_ANGLE_X: prdata = PDATA_W'(ang_reg[0]);
            REG_ANGLE_Y: prdata = PDATA_W'(ang_reg[1]);
            REG_ANGLE_Z: prdata = PDATA_W'(ang_reg[2]);
            REG_SHIFT_X: prdata = PDATA_W'(shf_reg[0]);
            REG_SHIFT_Y: prdata = PDATA_W'(shf_reg[1]);
            REG_SHIFT_Z: prdata = PDATA_W'(shf_reg[2]);
            default:     prdata = '0;
        endcase
    end

    // angle reduction into the cordic range
    logic signed [ANGLE_WIDTH-1:0] ang_sel;
    logic signed [Z_W-1:0] z_raw, z_red;
    logic flip_red;

    always_comb
    begin
        ang_sel = $signed(ang_reg[sel_reg]);
        z_raw   = Z_W'(ang_sel) <<< Z_SHIFT;
        flip_red = 1'b0;
        z_red   = z_raw;
        if (z_raw > HALF_PI_Q)
        begin
            z_red = PI_Q - z_raw;
            flip_red = 1'b1;
        end
        else if (z_raw < -HALF_PI_Q)
        begin
            z_red = -PI_Q - z_raw;
            flip_red = 1'b1;
        end
    end

    // one cordic rotation
    logic signed [XY_W-1:0] x_step, y_step, dx, dy;
    logic signed [Z_W-1:0] z_step;
    logic signed [Z_W-1:0] atan_v;

    always_comb
    begin
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        atan_v = atan_q30(step_reg);
        if (!z_reg[Z_W-1])
        begin
            x_step = x_reg - dx;
            y_step = y_reg + dy;
            z_step = z_reg - atan_v;
        end
        else
        begin
            x_step = x_reg + dx;
            y_step = y_reg - dy;
            z_step = z_reg + atan_v;
        end
    end

    // operands of the shared multiplier
    logic signed [TRIG_W-1:0] opa, opb;

    always_comb
    begin
        unique case (op_reg)
            OP_SXSY:   begin opa = sin_reg[0]; opb = sin_reg[1]; end
            OP_CXSY:   begin opa = cos_reg[0]; opb = sin_reg[1]; end
            OP_CYCZ:   begin opa = cos_reg[1]; opb = cos_reg[2]; end
            OP_CYSZ:   begin opa = cos_reg[1]; opb = sin_reg[2]; end
            OP_SXCY:   begin opa = sin_reg[0]; opb = cos_reg[1]; end
            OP_CXCY:   begin opa = cos_reg[0]; opb = cos_reg[1]; end
            OP_SXSYCZ: begin opa = res_reg[OP_SXSY]; opb = cos_reg[2]; end
            OP_CXSZ:   begin opa = cos_reg[0]; opb = sin_reg[2]; end
            OP_SXSYSZ: begin opa = res_reg[OP_SXSY]; opb = sin_reg[2]; end
            OP_CXCZ:   begin opa = cos_reg[0]; opb = cos_reg[2]; end
            OP_CXSYCZ: begin opa = res_reg[OP_CXSY]; opb = cos_reg[2]; end
            OP_SXSZ:   begin opa = sin_reg[0]; opb = sin_reg[2]; end
            OP_CXSYSZ: begin opa = res_reg[OP_CXSY]; opb = sin_reg[2]; end
            OP_SXCZ:   begin opa = sin_reg[0]; opb = cos_reg[2]; end
            default:   begin opa = '0; opb = '0; end
        endcase
    end

    logic signed [PROD2_W-1:0] rnd_full;
    assign rnd_full = (prod_reg + Q_HALF) >>> FRAC_BITS;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        op_next    = op_reg;
        unique case (state_reg)
            CS_IDLE: ;
            CS_LOAD:
            begin
                step_next = '0;
                if (ang_sel == '0)
                begin
                    if (sel_reg == 2'd2)
                    begin
                        op_next = OP_SXSY;
                        state_next = CS_MUL;
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                    end
                end
                else
                begin
                    state_next = CS_ROT;
                end
            end
            CS_ROT:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_STEP)
                begin
                    if (sel_reg == 2'd2)
                    begin
                        op_next = OP_SXSY;
                        state_next = CS_MUL;
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                        state_next = CS_LOAD;
                    end
                end
            end
            CS_MUL: state_next = CS_RND;
            CS_RND:
            begin
                if (op_reg == OP_SXCZ)
                begin
                    state_next = CS_MATRIX;
                end
                else
                begin
                    op_next = op_reg + 4'd1;
                    state_next = CS_MUL;
                end
            end
            CS_MATRIX: state_next = CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
        // any angle write restarts the whole build
        if (angle_wr)
        begin
            state_next = CS_LOAD;
            sel_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            sel_reg   <= '0;
            step_reg  <= '0;
            op_reg    <= OP_SXSY;
            for (int i = 0; i < 3; i++)
            begin
                sin_reg[i] <= '0;
                cos_reg[i] <= Q_ONE;
            end
            for (int i = 0; i < 9; i++)
            begin
                mat_reg[i] <= (i == 0 || i == 4 || i == 8) ? ENTRY_W'(Q_ONE) : '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            step_reg  <= step_next;
            op_reg    <= op_next;
            if (state_reg == CS_LOAD && ang_sel == '0)
            begin
                sin_reg[sel_reg] <= '0;
                cos_reg[sel_reg] <= Q_ONE;
            end
            if (state_reg == CS_ROT && step_reg == LAST_STEP)
            begin
                sin_reg[sel_reg] <= y_step[TRIG_W-1:0];
                cos_reg[sel_reg] <= flip_reg ? TRIG_W'(-x_step) : x_step[TRIG_W-1:0];
            end
            if (state_reg == CS_MATRIX)
            begin
                mat_reg[0] <= ENTRY_W'(res_reg[OP_CYCZ]);
                mat_reg[1] <= ENTRY_W'(res_reg[OP_CYSZ]);
                mat_reg[2] <= -ENTRY_W'(sin_reg[1]);
                mat_reg[3] <= ENTRY_W'(res_reg[OP_SXSYCZ]) - ENTRY_W'(res_reg[OP_CXSZ]);
                mat_reg[4] <= ENTRY_W'(res_reg[OP_SXSYSZ]) + ENTRY_W'(res_reg[OP_CXCZ]);
                mat_reg[5] <= ENTRY_W'(res_reg[OP_SXCY]);
                mat_reg[6] <= ENTRY_W'(res_reg[OP_CXSYCZ]) + ENTRY_W'(res_reg[OP_SXSZ]);
                mat_reg[7] <= ENTRY_W'(res_reg[OP_CXSYSZ]) - ENTRY_W'(res_reg[OP_SXCZ]);
                mat_reg[8] <= ENTRY_W'(res_reg[OP_CXCY]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == CS_LOAD)
        begin
            x_reg    <= GAIN_Q;
            y_reg    <= '0;
            z_reg    <= z_red;
            flip_reg <= flip_red;
        end
        else if (state_reg == CS_ROT)
        begin
            x_reg <= x_step;
            y_reg <= y_step;
            z_reg <= z_step;
        end
        if (state_reg == CS_MUL)
        begin
            prod_reg <= PROD2_W'(opa) * PROD2_W'(opb);
        end
        if (state_reg == CS_RND)
        begin
            res_reg[op_reg] <= rnd_full[TRIG_W-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            shift[i] = $signed(shf_reg[i]);
        end
        for (int i = 0; i < 9; i++)
        begin
            matrix[i] = mat_reg[i];
        end
    end

    assign status.busy = (state_reg != CS_IDLE);

endmodule
`default_nettype wire

/* rtl/erpt_front.sv */
// input side: accepts points into a short queue
`default_nettype none
module erpt_front #(
    parameter int COORD_WIDTH = erpt_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    erpt_point_if.sink                    point,
    input  erpt_pkg::coef_status_t        status,
    output logic                          q_valid,
    output logic [3*COORD_WIDTH-1:0]      q_data,
    input  wire logic                     q_pop
);
    import erpt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [3*COORD_WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic push, pop;

    // new points wait while the matrix is being rebuilt
    assign point.ready = (count_reg != CNT_W'(QUEUE_DEPTH)) && !status.busy;
    assign push = point.valid && point.ready;
    assign pop  = q_pop && q_valid;
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= {point.point_x, point.point_y, point.point_z};
        end
    end

endmodule
`default_nettype wire

/* rtl/erpt_back.sv */
// datapath: matrix times point, rounding, translation and saturation
`default_nettype none
module erpt_back #(
    parameter int COORD_WIDTH = erpt_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_valid,
    input  wire logic [3*COORD_WIDTH-1:0] q_data,
    output logic                          q_pop,
    input  erpt_pkg::entry_t              matrix [9],
    input  wire logic signed [COORD_WIDTH-1:0] shift [3],
    erpt_moved_if.source                  moved
);
    import erpt_pkg::*;

    localparam int LO_W   = COORD_WIDTH / 2;
    localparam int HI_W   = COORD_WIDTH - LO_W;
    localparam int PH_W   = ENTRY_W + HI_W;
    localparam int PL_W   = ENTRY_W + LO_W + 1;
    localparam int PROD_W = ENTRY_W + COORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_W  = SUM_W - FRAC_BITS;
    localparam int V_W    = RND_W + 1;
    localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(64'sd536870912);
    localparam logic signed [V_W-1:0] V_MAX = (V_W'(1) <<< (COORD_WIDTH - 1)) - V_W'(1);
    localparam logic signed [V_W-1:0] V_MIN = -(V_W'(1) <<< (COORD_WIDTH - 1));

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [PH_W-1:0] ph_reg [9];
    logic signed [PL_W-1:0] pl_reg [9];
    logic signed [PROD_W-1:0] pr_reg [9];
    logic signed [RND_W-1:0] rnd_reg [3];
    logic signed [COORD_WIDTH-1:0] out_reg [3];
    logic clip_reg;

    logic signed [COORD_WIDTH-1:0] pt [3];
    logic signed [SUM_W-1:0] sum [3];
    logic signed [SUM_W-1:0] sum_sh [3];
    logic signed [V_W-1:0] v [3];
    logic signed [COORD_WIDTH-1:0] sat [3];
    logic clip_any;

    // whole pipeline moves unless the result register is held
    assign en    = !v4_reg || moved.ready;
    assign q_pop = en;

    always_comb
    begin
        pt[0] = $signed(q_data[3*COORD_WIDTH-1:2*COORD_WIDTH]);
        pt[1] = $signed(q_data[2*COORD_WIDTH-1:COORD_WIDTH]);
        pt[2] = $signed(q_data[COORD_WIDTH-1:0]);
    end

    always_comb
    begin
        clip_any = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            sum[r] = SUM_W'(pr_reg[3*r]) + SUM_W'(pr_reg[3*r+1]) + SUM_W'(pr_reg[3*r+2]);
            sum_sh[r] = (sum[r] + HALF_S) >>> FRAC_BITS;
            v[r] = V_W'(rnd_reg[r]) + V_W'(shift[r]);
            if (v[r] > V_MAX)
            begin
                sat[r] = V_MAX[COORD_WIDTH-1:0];
                clip_any = 1'b1;
            end
            else if (v[r] < V_MIN)
            begin
                sat[r] = V_MIN[COORD_WIDTH-1:0];
                clip_any = 1'b1;
            end
            else
            begin
                sat[r] = v[r][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                // coordinate split into a signed high half and an unsigned low half
                ph_reg[i] <= PH_W'(matrix[i]) *
                             PH_W'($signed(pt[i%3][COORD_WIDTH-1:LO_W]));
                pl_reg[i] <= PL_W'(matrix[i]) *
                             PL_W'($signed({1'b0, pt[i%3][LO_W-1:0]}));
                pr_reg[i] <= (PROD_W'(ph_reg[i]) <<< LO_W) + PROD_W'(pl_reg[i]);
            end
            for (int r = 0; r < 3; r++)
            begin
                rnd_reg[r] <= sum_sh[r][RND_W-1:0];
                out_reg[r] <= sat[r];
            end
            clip_reg <= clip_any;
        end
    end

    assign moved.valid   = v4_reg;
    assign moved.moved_x = out_reg[0];
    assign moved.moved_y = out_reg[1];
    assign moved.moved_z = out_reg[2];
    assign moved.clipped = clip_reg;

endmodule
`default_nettype wire

/* rtl/euler_rigid_point_transform.sv */
// a point passes the queue, 2 multiply, sum and saturate registers to the result
// throughput: one point per cycle, four-stage multiply-add pipeline, unless stalled
// an angle write rebuilds the matrix on one shared cordic and multiplier;
//   points wait until the rebuild is done
// reset: asynchronous, zeroes control and config registers, matrix to identity
`default_nettype none
module euler_rigid_point_transform #(
    parameter int COORD_WIDTH  = erpt_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = erpt_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = erpt_pkg::CORDIC_STEPS_DEF,
    parameter int PDATA_W      = (COORD_WIDTH > 32) ? 64 : 32,
    parameter int ADDR_LSB     = (COORD_WIDTH > 32) ? 3 : 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_LSB+2:0] paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready,
    erpt_point_if.sink               point,
    erpt_moved_if.source             moved
);
    import erpt_pkg::*;

    localparam logic [COORD_WIDTH-1:0] RAIL_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] RAIL_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    entry_t matrix [9];
    logic signed [COORD_WIDTH-1:0] shift [3];
    coef_status_t status;
    logic q_valid, q_pop;
    logic [3*COORD_WIDTH-1:0] q_data;
    logic angle_wr;

    assign pready = 1'b1;

    erpt_coef #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .CORDIC_STEPS(CORDIC_STEPS),
        .PDATA_W     (PDATA_W),
        .ADDR_LSB    (ADDR_LSB)
    ) u_coef (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .matrix (matrix),
        .shift  (shift),
        .status (status)
    );

    erpt_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point),
        .status (status),
        .q_valid(q_valid),
        .q_data (q_data),
        .q_pop  (q_pop)
    );

    erpt_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_valid(q_valid),
        .q_data (q_data),
        .q_pop  (q_pop),
        .matrix (matrix),
        .shift  (shift),
        .moved  (moved)
    );

    assign angle_wr = psel && penable && pwrite
                      && (paddr[ADDR_LSB+2:ADDR_LSB] == REG_ANGLE_X
                          || paddr[ADDR_LSB+2:ADDR_LSB] == REG_ANGLE_Y
                          || paddr[ADDR_LSB+2:ADDR_LSB] == REG_ANGLE_Z);

    // no point enters while the matrix is rebuilt
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !point.ready)
        else $error("point accepted during matrix rebuild");

    // an angle write starts a rebuild
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        angle_wr |=> status.busy)
        else $error("angle write did not start a rebuild");

    // a clipped result has at least one coordinate on a rail
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (moved.valid && moved.clipped) |->
            (moved.moved_x == RAIL_MAX || moved.moved_x == RAIL_MIN
             || moved.moved_y == RAIL_MAX || moved.moved_y == RAIL_MIN
             || moved.moved_z == RAIL_MAX || moved.moved_z == RAIL_MIN))
        else $error("clip flag without a saturated coordinate");

endmodule
`default_nettype wire
